@@ hdl/crc_fcc_pkg.sv @@
// Package for the CRC frame checker: register indexes, field widths,
// reset values and the structs passed between its modules. No dependencies.
package crc_fcc_pkg;

	localparam int DEFAULT_MAX_DEGREE = 32;

	localparam int DEGREE_W   = 6;
	localparam int TAPS_W     = 32;
	localparam int REM_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLY_TAPS   = 1'd1;

	localparam logic [DEGREE_W-1:0] POLY_DEGREE_RESET = 6'd8;
	localparam logic [TAPS_W-1:0]   POLY_TAPS_RESET   = 32'd7;

	// One division step request from the input stage
	typedef struct packed {
		logic fire;
		logic data_bit;
		logic last_bit;
	} step_t;

	typedef struct packed {
		logic [DEGREE_W-1:0] degree;
		logic [TAPS_W-1:0]   taps;
	} poly_cfg_t;

endpackage

@@ hdl/crc_fcc_if.sv @@
// Channel interfaces of the CRC frame checker: frame bits in, results out.
// Depends on crc_fcc_pkg for field widths.
interface crc_fcc_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last_bit;

	modport source (output valid, output data_bit, output last_bit, input ready);
	modport sink   (input valid, input data_bit, input last_bit, output ready);
endinterface

interface crc_fcc_res_if;
	logic                       valid;
	logic                       ready;
	logic [crc_fcc_pkg::REM_W-1:0] remainder;
	logic                       error_found;

	modport source (output valid, output remainder, output error_found, input ready);
	modport sink   (input valid, input remainder, input error_found, output ready);
endinterface

@@ hdl/crc_fcc_div.sv @@
// Bit-serial GF(2) division register of the CRC frame checker.
// Depends on crc_fcc_pkg (step_t, poly_cfg_t, widths).
module crc_fcc_div #(
	parameter int MAX_DEGREE = crc_fcc_pkg::DEFAULT_MAX_DEGREE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  crc_fcc_pkg::step_t        step,
	input  crc_fcc_pkg::poly_cfg_t    cfg,
	output logic [crc_fcc_pkg::REM_W-1:0] rem_next,
	output logic                      err_next
);
	import crc_fcc_pkg::*;

	localparam int DW = 7; // holds degrees up to 127

	logic [MAX_DEGREE-1:0]        div_q;
	logic [MAX_DEGREE-1:0]        mask;
	logic [MAX_DEGREE-1:0]        taps_ext;
	logic [MAX_DEGREE-1:0]        next_val;
	logic [MAX_DEGREE:0]          shift_wide;
	logic [MAX_DEGREE+TAPS_W-1:0] taps_wide;
	logic [MAX_DEGREE+REM_W-1:0]  rem_wide;
	logic [DW-1:0]                deg_raw;
	logic [DW-1:0]                deg_eff;
	logic                         top;

	always_comb begin
		deg_raw = DW'(cfg.degree);
		deg_eff = (deg_raw > DW'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : deg_raw;
		taps_wide = {{MAX_DEGREE{1'b0}}, cfg.taps};
		taps_ext  = taps_wide[MAX_DEGREE-1:0];
		top = 1'b0;
		for (int i = 0; i < MAX_DEGREE; i++) begin
			mask[i] = (DW'(i) < deg_eff);
			if (DW'(i + 1) == deg_eff)
				top = div_q[i];
		end
		// shift the new bit in; the bit shifted out the top selects the taps xor
		shift_wide = {div_q, step.data_bit};
		next_val = (shift_wide[MAX_DEGREE-1:0] & mask)
			^ ({MAX_DEGREE{top}} & taps_ext & mask);
		rem_wide = {{REM_W{1'b0}}, next_val};
		rem_next = rem_wide[REM_W-1:0];
		err_next = |next_val;
	end

	// Frame end clears the register for the next frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else if (step.fire) begin
			div_q <= step.last_bit ? '0 : next_val;
		end
	end

endmodule

@@ hdl/crc_fcc_out.sv @@
// Result register of the CRC frame checker, drives the result channel.
// Depends on crc_fcc_pkg and crc_fcc_res_if.
module crc_fcc_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [crc_fcc_pkg::REM_W-1:0] rem_in,
	input  logic                          err_in,
	output logic                          busy,
	crc_fcc_res_if.source                 result
);
	import crc_fcc_pkg::*;

	logic             valid_q;
	logic [REM_W-1:0] rem_q;
	logic             err_q;

	// slot stays taken while the receiver stalls
	assign busy = valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_in;
			err_q <= err_in;
		end
	end

	assign result.valid       = valid_q;
	assign result.remainder   = rem_q;
	assign result.error_found = err_q;

endmodule

@@ hdl/crc_frame_checker_core.sv @@
// Top level of the CRC frame checker: input stage, config registers,
// division register and result register. Depends on crc_fcc_pkg, the
// channel interfaces, crc_fcc_div and crc_fcc_out.
//
// Usage:
//   frame  - one frame bit per request, first bit first, last_bit on the
//            final bit (check bits included). Every bit takes one request.
//   result - one request per frame: remainder of the whole frame modulo
//            x^degree + taps, and error_found when it is nonzero.
//   wr_*   - register writes (poly_degree, poly_taps), only while idle.
// Path: a last bit accepted goes into the input register, then one
//   division step loads the result register, which raises result.valid.
// Throughput: one bit per cycle while the input stage can advance; a last
//   bit waits while a stalled result holds the result slot.
// Reset: degree 8, taps 7, division register zero, nothing pending.
// Stall: the result register holds its result while result.ready is low;
//   ordinary bits keep flowing. A further last bit waits in the input
//   register, and frame.ready drops until the result slot frees.
module crc_frame_checker_core #(
	parameter int MAX_DEGREE = crc_fcc_pkg::DEFAULT_MAX_DEGREE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [crc_fcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [crc_fcc_pkg::CFG_DATA_W-1:0] wr_data,
	crc_fcc_bit_if.sink                        frame,
	crc_fcc_res_if.source                      result
);
	import crc_fcc_pkg::*;

	poly_cfg_t        cfg_q;
	logic             valid_s1;
	logic             data_bit_s1;
	logic             last_bit_s1;
	logic             advance;
	logic             out_busy;
	step_t            step;
	logic [REM_W-1:0] rem_next;
	logic             err_next;

	// Config registers, to be written only between frames; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree <= POLY_DEGREE_RESET;
			cfg_q.taps   <= POLY_TAPS_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POLY_DEGREE: cfg_q.degree <= wr_data[DEGREE_W-1:0];
				REG_POLY_TAPS:   cfg_q.taps   <= wr_data[TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Input stage moves on unless a last bit must wait for the result slot
	assign advance     = !(last_bit_s1 && out_busy);
	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready) begin
			data_bit_s1 <= frame.data_bit;
			last_bit_s1 <= frame.last_bit;
		end
	end

	always_comb begin
		step.fire     = valid_s1 && advance;
		step.data_bit = data_bit_s1;
		step.last_bit = last_bit_s1;
	end

	crc_fcc_div #(
		.MAX_DEGREE (MAX_DEGREE)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg      (cfg_q),
		.rem_next (rem_next),
		.err_next (err_next)
	);

	crc_fcc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step.fire && step.last_bit),
		.rem_in (rem_next),
		.err_in (err_next),
		.busy   (out_busy),
		.result (result)
	);

	// A fresh result only follows a last bit leaving the input stage
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(valid_s1 && last_bit_s1))
		else $error("result without a frame end");

	// Pass means an all-zero remainder
	a_pass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.error_found) |-> (result.remainder == '0))
		else $error("pass flag with nonzero remainder");

	// A held last bit stays put until the result slot frees
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && last_bit_s1 && $stable(data_bit_s1)))
		else $error("waiting frame end lost");

	// No new result is loaded over one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |=> (result.valid && $stable(result.remainder)))
		else $error("stalled result overwritten");

endmodule
